>>> design/bps_pkg.sv
// Package for the ballistic pitch solver: field widths, register map,
// queue entry and pipeline sideband types, and the CORDIC angle table.
// No dependencies.
package bps_pkg;

	localparam int GRAV_W = 21;
	localparam logic [GRAV_W-1:0] GRAVITY_RESET = 21'd641158;

	// Register map: index is paddr[2]
	localparam int PADDR_W = 3;
	localparam logic REG_GRAVITY = 1'b0;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam int CORDIC_STEPS = 24;
	localparam int PITCH_MAX = 102944;

	// Request as classified by the front end
	typedef struct packed {
		logic [15:0]        v0;
		logic [15:0]        d;
		logic signed [15:0] h;
		logic               zero;
		logic [31:0]        d2;
		logic [31:0]        v2;
	} bps_item_t;

	// Sideband through the drop divider
	typedef struct packed {
		logic [15:0]        v0;
		logic [15:0]        d;
		logic signed [15:0] h;
		logic [31:0]        d2;
		logic               bad;
	} bps_ksb_t;

	// Sideband through the discriminant root
	typedef struct packed {
		logic [15:0]        v0;
		logic [15:0]        d;
		logic signed [26:0] n;
		logic               bad;
	} bps_ssb_t;

	// Sideband through the CORDIC stages
	typedef struct packed {
		logic [15:0]        v0;
		logic [15:0]        d;
		logic [25:0]        m;
		logic signed [26:0] n;
		logic               bad;
	} bps_csb_t;

	// Sideband through the radius root
	typedef struct packed {
		logic [15:0]        v0;
		logic [15:0]        d;
		logic [25:0]        m;
		logic signed [17:0] pitch;
		logic               bad;
	} bps_rsb_t;

	// Sideband through the flight time divider
	typedef struct packed {
		logic signed [17:0] pitch;
		logic               bad;
		logic               sat;
	} bps_tsb_t;

	// Result entry
	typedef struct packed {
		logic               oor;
		logic signed [17:0] pitch;
		logic [31:0]        ftime;
	} bps_res_t;

	// atan(2^-i) in units of 2^-24 rad
	function automatic logic [24:0] bps_atan(input logic [4:0] i);
		logic [24:0] a;
		unique case (i)
			5'd0:    a = 25'd13176795;
			5'd1:    a = 25'd7778716;
			5'd2:    a = 25'd4110060;
			5'd3:    a = 25'd2086331;
			5'd4:    a = 25'd1047214;
			5'd5:    a = 25'd524117;
			5'd6:    a = 25'd262123;
			5'd7:    a = 25'd131069;
			5'd8:    a = 25'd65536;
			5'd9:    a = 25'd32768;
			5'd10:   a = 25'd16384;
			5'd11:   a = 25'd8192;
			5'd12:   a = 25'd4096;
			5'd13:   a = 25'd2048;
			5'd14:   a = 25'd1024;
			5'd15:   a = 25'd512;
			5'd16:   a = 25'd256;
			5'd17:   a = 25'd128;
			5'd18:   a = 25'd64;
			5'd19:   a = 25'd32;
			5'd20:   a = 25'd16;
			5'd21:   a = 25'd8;
			5'd22:   a = 25'd4;
			5'd23:   a = 25'd2;
			default: a = 25'd0;
		endcase
		return a;
	endfunction

endpackage

>>> design/bps_fifo.sv
// Small register-based FIFO used for the middle queue and the result queue.
// Depends on nothing.
module bps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_rd_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("fifo count did not drop on read");

	a_wr_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> !empty)
		else $error("fifo empty after write");

endmodule

>>> design/bps_front.sv
// Front end: accepts requests, flags zero speed or distance and forms the
// squares of distance and speed. Depends on bps_pkg.
module bps_front (
	input  logic                  push,
	input  logic                  mid_full,
	input  logic [15:0]           muzzle_speed,
	input  logic [15:0]           horizontal_distance,
	input  logic signed [15:0]    target_height,
	output logic                  mid_wr,
	output bps_pkg::bps_item_t    item
);

	// Accept when the middle queue has room
	assign mid_wr = push && !mid_full;

	// Classify and square
	always_comb begin
		item.v0   = muzzle_speed;
		item.d    = horizontal_distance;
		item.h    = target_height;
		item.zero = (muzzle_speed == '0) || (horizontal_distance == '0);
		item.d2   = 32'(horizontal_distance) * 32'(horizontal_distance);
		item.v2   = 32'(muzzle_speed) * 32'(muzzle_speed);
	end

endmodule

>>> design/bps_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Quotient must be below 2^QW. Depends on nothing.
module bps_div_pipe #(
	parameter int NW = 16,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] sb_in,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] sb_out
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] dv_s  [QW];
	logic [SW-1:0] sb_s  [QW];
	logic          vld_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [NW-1:0] rem_p;
		logic [QW-1:0] q_p;
		logic [DW-1:0] dv_p;
		logic [SW-1:0] sb_p;
		logic          v_p;
		logic [CW-1:0] shd;
		logic [CW-1:0] diff;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_p = dividend;
			assign q_p   = '0;
			assign dv_p  = divisor;
			assign sb_p  = sb_in;
			assign v_p   = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign q_p   = q_s[j-1];
			assign dv_p  = dv_s[j-1];
			assign sb_p  = sb_s[j-1];
			assign v_p   = vld_s[j-1];
		end

		// Trial subtract of the shifted divisor
		assign shd  = CW'(dv_p) << (QW - 1 - j);
		assign take = CW'(rem_p) >= shd;
		assign diff = CW'(rem_p) - shd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? diff[NW-1:0] : rem_p;
				q_s[j]   <= {q_p[QW-2:0], take};
				dv_s[j]  <= dv_p;
				sb_s[j]  <= sb_p;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quot      = q_s[QW-1];
	assign sb_out    = sb_s[QW-1];

endmodule

>>> design/bps_sqrt_pipe.sv
// Pipelined floor square root, one root bit per stage, with a sideband
// that travels alongside. Depends on nothing.
module bps_sqrt_pipe #(
	parameter int RW = 8,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] value,
	input  logic [SW-1:0]   sb_in,
	output logic            out_valid,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   sb_out
);

	localparam int VW = 2 * RW;
	localparam int RR = RW + 4;

	logic [RR-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [VW-1:0] val_s  [RW];
	logic [SW-1:0] sb_s   [RW];
	logic          vld_s  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic [RR-1:0] rem_p;
		logic [RW-1:0] root_p;
		logic [VW-1:0] val_p;
		logic [SW-1:0] sb_p;
		logic          v_p;
		logic [RR-1:0] cat;
		logic [RR-1:0] trial;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign val_p  = value;
			assign sb_p   = sb_in;
			assign v_p    = in_valid;
		end else begin : g_next
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign val_p  = val_s[j-1];
			assign sb_p   = sb_s[j-1];
			assign v_p    = vld_s[j-1];
		end

		// Bring down two bits and try 4q+1
		assign cat   = {rem_p[RR-3:0], val_p[VW-1:VW-2]};
		assign trial = RR'({root_p, 2'b01});
		assign take  = cat >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? cat - trial : cat;
				root_s[j] <= {root_p[RW-2:0], take};
				val_s[j]  <= {val_p[VW-3:0], 2'b00};
				sb_s[j]   <= sb_p;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign sb_out    = sb_s[RW-1];

endmodule

>>> design/bps_back.sv
// Back end: solver pipeline from the middle queue to the result queue
// (drop divider, discriminant root, CORDIC, radius root, time divider).
// Depends on bps_pkg, bps_div_pipe and bps_sqrt_pipe.
module bps_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bps_pkg::GRAV_W-1:0]  gravity,
	input  logic                        mid_empty,
	input  bps_pkg::bps_item_t          mid_item,
	output logic                        mid_rd,
	input  logic                        out_full,
	output logic                        res_we,
	output bps_pkg::bps_res_t           res
);

	localparam int NS = bps_pkg::CORDIC_STEPS;

	logic en;
	logic [30:0] ga_q;

	// Whole pipeline advances while the result queue has room
	assign en     = !out_full;
	assign mid_rd = en && !mid_empty;

	// Gravity times 1000, from configuration
	always_ff @(posedge clk) begin
		ga_q <= {10'd0, gravity} * 31'd1000;
	end

	// Stage 1: take the request
	bps_pkg::bps_item_t it_s1;
	logic vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !mid_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= mid_item;
		end
	end

	// Stage 2: drop numerator, denominator and limit bound
	logic [62:0] num_s2;
	logic [39:0] den_s2;
	logic [65:0] denk_s2;
	bps_pkg::bps_ksb_t ksb_s2;
	logic vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2     <= {32'd0, ga_q} * {31'd0, it_s1.d2};
			den_s2     <= {it_s1.v2, 8'd0};
			denk_s2    <= {1'b0, it_s1.v2, 33'd0} + {26'd0, it_s1.v2, 8'd0};
			ksb_s2.v0  <= it_s1.v0;
			ksb_s2.d   <= it_s1.d;
			ksb_s2.h   <= it_s1.h;
			ksb_s2.d2  <= it_s1.d2;
			ksb_s2.bad <= it_s1.zero;
		end
	end

	// Drop divider: K = num / den, flagged when K exceeds the limit
	bps_pkg::bps_ksb_t k_in;
	bps_pkg::bps_ksb_t k_sb;
	logic [$bits(bps_pkg::bps_ksb_t)-1:0] k_inv;
	logic [$bits(bps_pkg::bps_ksb_t)-1:0] k_sbv;
	logic [25:0] k_q;
	logic k_vld;

	always_comb begin
		k_in     = ksb_s2;
		k_in.bad = ksb_s2.bad || ({3'd0, num_s2} >= denk_s2);
	end
	assign k_inv = k_in;
	assign k_sb  = bps_pkg::bps_ksb_t'(k_sbv);

	bps_div_pipe #(
		.NW(63), .DW(40), .QW(26), .SW($bits(bps_pkg::bps_ksb_t))
	) u_div_k (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .dividend(num_s2), .divisor(den_s2), .sb_in(k_inv),
		.out_valid(k_vld), .quot(k_q), .sb_out(k_sbv)
	);

	// Stage 3: N = K + 512 h
	logic [25:0] k_s3;
	logic signed [26:0] n_s3;
	bps_pkg::bps_ksb_t ksb_s3;
	logic vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= k_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s3   <= k_q;
			n_s3   <= $signed({1'b0, k_q}) + $signed({{2{k_sb.h[15]}}, k_sb.h, 9'd0});
			ksb_s3 <= k_sb;
		end
	end

	// Stage 4: K*N and d^2 scaled
	logic signed [53:0] kn_s4;
	logic [47:0] dd_s4;
	bps_pkg::bps_ssb_t ssb_s4;
	logic vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kn_s4      <= $signed({1'b0, k_s3}) * n_s3;
			dd_s4      <= {ksb_s3.d2, 16'd0};
			ssb_s4.v0  <= ksb_s3.v0;
			ssb_s4.d   <= ksb_s3.d;
			ssb_s4.n   <= n_s3;
			ssb_s4.bad <= ksb_s3.bad;
		end
	end

	// Discriminant root, flagged when negative
	logic [54:0] disc;
	bps_pkg::bps_ssb_t s_in;
	bps_pkg::bps_ssb_t s_sb;
	logic [$bits(bps_pkg::bps_ssb_t)-1:0] s_inv;
	logic [$bits(bps_pkg::bps_ssb_t)-1:0] s_sbv;
	logic [49:0] s_val;
	logic [24:0] s_root;
	logic s_vld;

	assign disc = {7'd0, dd_s4} - {kn_s4[53], kn_s4};
	always_comb begin
		s_in     = ssb_s4;
		s_in.bad = ssb_s4.bad || disc[54];
	end
	assign s_val = s_in.bad ? '0 : disc[49:0];
	assign s_inv = s_in;
	assign s_sb  = bps_pkg::bps_ssb_t'(s_sbv);

	bps_sqrt_pipe #(
		.RW(25), .SW($bits(bps_pkg::bps_ssb_t))
	) u_sqrt_d (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s4), .value(s_val), .sb_in(s_inv),
		.out_valid(s_vld), .root(s_root), .sb_out(s_sbv)
	);

	// Stage 5: M = 256 d + S
	bps_pkg::bps_csb_t csb_s5;
	logic vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= s_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			csb_s5.v0  <= s_sb.v0;
			csb_s5.d   <= s_sb.d;
			csb_s5.m   <= {2'b00, s_sb.d, 8'd0} + {1'b0, s_root};
			csb_s5.n   <= s_sb.n;
			csb_s5.bad <= s_sb.bad;
		end
	end

	// CORDIC vectoring on (64 M, 64 N), one rotation per stage
	logic signed [35:0] cx_s [NS];
	logic signed [35:0] cy_s [NS];
	logic signed [26:0] cz_s [NS];
	bps_pkg::bps_csb_t  csb_s [NS];
	logic               cv_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		logic signed [35:0] xp;
		logic signed [35:0] yp;
		logic signed [26:0] zp;
		bps_pkg::bps_csb_t  sp;
		logic               vp;
		logic signed [35:0] dx;
		logic signed [35:0] dy;
		logic signed [26:0] ang;

		if (i == 0) begin : g_first
			assign xp = $signed({4'd0, csb_s5.m, 6'd0});
			assign yp = $signed({{3{csb_s5.n[26]}}, csb_s5.n, 6'd0});
			assign zp = '0;
			assign sp = csb_s5;
			assign vp = vld_s5;
		end else begin : g_next
			assign xp = cx_s[i-1];
			assign yp = cy_s[i-1];
			assign zp = cz_s[i-1];
			assign sp = csb_s[i-1];
			assign vp = cv_s[i-1];
		end

		assign dx  = yp >>> i;
		assign dy  = xp >>> i;
		assign ang = $signed({2'b00, bps_pkg::bps_atan(5'(i))});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i] <= 1'b0;
			end else if (en) begin
				cv_s[i] <= vp;
			end
		end

		// Rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yp[35]) begin
					cx_s[i] <= xp + dx;
					cy_s[i] <= yp - dy;
					cz_s[i] <= zp + ang;
				end else begin
					cx_s[i] <= xp - dx;
					cy_s[i] <= yp + dy;
					cz_s[i] <= zp - ang;
				end
				csb_s[i] <= sp;
			end
		end
	end

	// Stage 6: round and clamp pitch, square M and N
	logic signed [26:0] zr;
	logic signed [26:0] zsh;
	logic signed [17:0] pitch_c;
	logic signed [26:0] pmax;
	logic [51:0] m2_s6;
	logic signed [53:0] n2_s6;
	bps_pkg::bps_rsb_t rsb_s6;
	logic vld_s6;

	assign pmax = $signed(27'(bps_pkg::PITCH_MAX));
	assign zr   = cz_s[NS-1] + 27'sd128;
	assign zsh  = zr >>> 8;
	always_comb begin
		if (zsh > pmax) begin
			pitch_c = pmax[17:0];
		end else if (zsh < -pmax) begin
			pitch_c = -pmax[17:0];
		end else begin
			pitch_c = zsh[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= cv_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s6        <= 52'(csb_s[NS-1].m) * 52'(csb_s[NS-1].m);
			n2_s6        <= csb_s[NS-1].n * csb_s[NS-1].n;
			rsb_s6.v0    <= csb_s[NS-1].v0;
			rsb_s6.d     <= csb_s[NS-1].d;
			rsb_s6.m     <= csb_s[NS-1].m;
			rsb_s6.pitch <= pitch_c;
			rsb_s6.bad   <= csb_s[NS-1].bad;
		end
	end

	// Radius root R = sqrt(M^2 + N^2)
	logic [53:0] r_val;
	bps_pkg::bps_rsb_t r_sb;
	logic [$bits(bps_pkg::bps_rsb_t)-1:0] r_inv;
	logic [$bits(bps_pkg::bps_rsb_t)-1:0] r_sbv;
	logic [26:0] r_root;
	logic r_vld;

	assign r_val = rsb_s6.bad ? '0 : {2'b00, m2_s6} + $unsigned(n2_s6);
	assign r_inv = rsb_s6;
	assign r_sb  = bps_pkg::bps_rsb_t'(r_sbv);

	bps_sqrt_pipe #(
		.RW(27), .SW($bits(bps_pkg::bps_rsb_t))
	) u_sqrt_r (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s6), .value(r_val), .sb_in(r_inv),
		.out_valid(r_vld), .root(r_root), .sb_out(r_sbv)
	);

	// Stage 7: d*R and M*v0
	logic [42:0] dr_s7;
	logic [41:0] mv_s7;
	bps_pkg::bps_tsb_t tsb_s7;
	logic vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s7        <= 43'(r_sb.d) * 43'(r_root);
			mv_s7        <= 42'(r_sb.m) * 42'(r_sb.v0);
			tsb_s7.pitch <= r_sb.pitch;
			tsb_s7.bad   <= r_sb.bad;
			tsb_s7.sat   <= 1'b0;
		end
	end

	// Stage 8: scale to microseconds
	logic [62:0] numt_s8;
	logic [41:0] mv_s8;
	bps_pkg::bps_tsb_t tsb_s8;
	logic vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numt_s8 <= 63'(dr_s7) * 63'd1000000;
			mv_s8   <= mv_s7;
			tsb_s8  <= tsb_s7;
		end
	end

	// Flight time divider, saturated when the quotient needs more than 32 bits
	bps_pkg::bps_tsb_t t_in;
	bps_pkg::bps_tsb_t t_sb;
	logic [$bits(bps_pkg::bps_tsb_t)-1:0] t_inv;
	logic [$bits(bps_pkg::bps_tsb_t)-1:0] t_sbv;
	logic [62:0] t_num;
	logic [31:0] t_q;
	logic t_vld;

	always_comb begin
		t_in     = tsb_s8;
		t_in.sat = {11'd0, numt_s8} >= {mv_s8, 32'd0};
	end
	assign t_num = t_in.sat ? '0 : numt_s8;
	assign t_inv = t_in;
	assign t_sb  = bps_pkg::bps_tsb_t'(t_sbv);

	bps_div_pipe #(
		.NW(63), .DW(42), .QW(32), .SW($bits(bps_pkg::bps_tsb_t))
	) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s8), .dividend(t_num), .divisor(mv_s8), .sb_in(t_inv),
		.out_valid(t_vld), .quot(t_q), .sb_out(t_sbv)
	);

	// Assemble the result; zero pitch and time when unsolvable, all-ones time when saturated
	assign res_we = t_vld && en;
	always_comb begin
		res.oor   = t_sb.bad;
		res.pitch = t_sb.bad ? '0 : t_sb.pitch;
		if (t_sb.bad) begin
			res.ftime = '0;
		end else if (t_sb.sat) begin
			res.ftime = '1;
		end else begin
			res.ftime = t_q;
		end
	end

endmodule

>>> design/ballistic_pitch_solver.sv
// Top level of the ballistic pitch solver: gravity register on the APB-style
// port, front end, middle queue, solver back end and result queue.
// Depends on bps_pkg, bps_front, bps_fifo and bps_back.

// The solver takes one request per clock while the middle queue is not full
// and returns results in order. A request passes from push through the
// middle queue and the back-end pipeline to the head of the result queue;
// the pipeline depth comes from the restoring dividers and square roots,
// which resolve one bit per stage, and from the 24 CORDIC stages. The whole
// back end holds while the result queue is full; the middle queue then
// absorbs a few further pushes before full rises. Gravity lives at byte
// address 0 and should only be written while no request is in flight.
module ballistic_pitch_solver #(
	parameter int MID_DEPTH = bps_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = bps_pkg::OUT_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bps_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic [15:0]                  muzzle_speed,
	input  logic [15:0]                  horizontal_distance,
	input  logic signed [15:0]           target_height,
	output logic                         empty,
	input  logic                         pop,
	output logic                         out_of_range,
	output logic signed [17:0]           launch_pitch,
	output logic [31:0]                  flight_time
);

	logic [bps_pkg::GRAV_W-1:0] gravity_q;
	logic reg_idx;
	logic cfg_we;

	bps_pkg::bps_item_t front_item;
	bps_pkg::bps_item_t mid_item;
	logic [$bits(bps_pkg::bps_item_t)-1:0] mid_rdv;
	logic mid_wr;
	logic mid_rd;
	logic mid_empty;
	bps_pkg::bps_res_t res;
	bps_pkg::bps_res_t head;
	logic [$bits(bps_pkg::bps_res_t)-1:0] head_v;
	logic res_we;
	logic out_full;

	// Register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == bps_pkg::REG_GRAVITY);
	assign prdata  = (reg_idx == bps_pkg::REG_GRAVITY) ?
		{{(32 - bps_pkg::GRAV_W){1'b0}}, gravity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= bps_pkg::GRAVITY_RESET;
		end else if (cfg_we) begin
			gravity_q <= pwdata[bps_pkg::GRAV_W-1:0];
		end
	end

	bps_front u_front (
		.push(push), .mid_full(full),
		.muzzle_speed(muzzle_speed), .horizontal_distance(horizontal_distance),
		.target_height(target_height), .mid_wr(mid_wr), .item(front_item)
	);

	bps_fifo #(
		.WIDTH($bits(bps_pkg::bps_item_t)), .DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk(clk), .arst_n(arst_n), .wr(mid_wr), .wdata(front_item),
		.rd(mid_rd), .rdata(mid_rdv), .full(full), .empty(mid_empty)
	);

	assign mid_item = bps_pkg::bps_item_t'(mid_rdv);

	bps_back u_back (
		.clk(clk), .arst_n(arst_n), .gravity(gravity_q),
		.mid_empty(mid_empty), .mid_item(mid_item), .mid_rd(mid_rd),
		.out_full(out_full), .res_we(res_we), .res(res)
	);

	bps_fifo #(
		.WIDTH($bits(bps_pkg::bps_res_t)), .DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk(clk), .arst_n(arst_n), .wr(res_we), .wdata(res),
		.rd(pop), .rdata(head_v), .full(out_full), .empty(empty)
	);

	// Present the oldest result
	assign head         = bps_pkg::bps_res_t'(head_v);
	assign out_of_range = head.oor;
	assign launch_pitch = head.pitch;
	assign flight_time  = head.ftime;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_of_range) |-> (launch_pitch == '0 && flight_time == '0))
		else $error("unsolvable result carries pitch or time");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (launch_pitch <= 18'sd102944 && launch_pitch >= -18'sd102944))
		else $error("pitch outside clamp");

endmodule
